>>> hdl/text_console_cursor_scroll_defines.svh
// Assertion macros shared by the console RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Same-cycle implication, off while in reset
`define TCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("console assertion failed in %m");

// Next-cycle implication, off while in reset
`define TCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("console assertion failed in %m");

`endif

>>> hdl/tcc_pkg.sv
// Shared types and constants of the text console.
// No dependencies; used by the interfaces, the RAM wrapper users and the top level.
package tcc_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int LAST_CELL  = CELL_COUNT - 1;
	localparam int COPY_CELLS = CELL_COUNT - COLUMNS;

	// Field widths
	localparam int ADDR_W   = $clog2(CELL_COUNT);
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = ATTR_W + CHAR_W;
	localparam int ACTION_W = 2;

	// Reset attribute: white on black
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	// Character codes with special meaning
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT   = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

endpackage

>>> hdl/tcc_in_if.sv
// Input channel of the text console: valid/ready plus one action beat.
// Depends on tcc_pkg for field widths.
interface tcc_in_if;
	logic                           valid;
	logic                           ready;
	logic [tcc_pkg::ACTION_W-1:0]   action;
	logic [tcc_pkg::CHAR_W-1:0]     char_code;
	logic [tcc_pkg::ADDR_W-1:0]     cell_index;

	modport source (output valid, output action, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input action, input char_code, input cell_index,
		output ready);
endinterface

>>> hdl/tcc_out_if.sv
// Output channel of the text console: valid/ready plus one result beat.
// Depends on tcc_pkg for field widths.
interface tcc_out_if;
	logic                         valid;
	logic                         ready;
	logic [tcc_pkg::COL_W-1:0]    cursor_column;
	logic [tcc_pkg::ROW_W-1:0]    cursor_row;
	logic [tcc_pkg::CELL_W-1:0]   cell_data;

	modport source (output valid, output cursor_column, output cursor_row,
		output cell_data, input ready);
	modport sink (input valid, input cursor_column, input cursor_row,
		input cell_data, output ready);
endinterface

>>> hdl/tcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/text_console_cursor_scroll.sv
// Text console engine: 80x25 cell buffer with cursor, scroll and clear.
// Channels: in_ch takes one action beat (put char, read cell, clear screen)
// when valid and ready are both high; out_ch returns one result beat per
// action with the cursor after the action and, for a read, the cell word.
// cfg_we/cfg_wdata write the attribute byte used for new cells; write it only
// while the block is idle.
// Flow: a put or an unused action goes from accept to the done state and then the
// output register; a read passes through a read state first for the registered RAM
// read. A clear, or a put that moves past the last row, sweeps all 2000 cells
// through the single RAM write port, one cell per cycle; during a scroll each cell
// is read one row below and written back in the next cycle.
// Reset: the cursor goes to the top left and the attribute to 0x0F, then a
// clearing pass over all 2000 cells zeroes the buffer; in_ch.ready stays low until
// its last write is done, config writes are taken throughout.
// Stall: the finished result sits in an output register; the next beat is
// accepted meanwhile, and that item holds its result until the register frees.
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcc_pkg::ATTR_W-1:0]  cfg_wdata,
	tcc_in_if.sink                      in_ch,
	tcc_out_if.source                   out_ch
);
	import tcc_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		WK_ZERO,
		WK_COPY,
		WK_BLANK
	} wr_kind_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    sweep_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [ATTR_W-1:0]    attr_q;
	logic [CELL_W-1:0]    res_data_q;
	logic                 out_valid_q;
	logic [COL_W-1:0]     out_col_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [CELL_W-1:0]    out_data_q;

	// Sweep write stage: the write of a swept cell comes in the cycle after its read
	logic                 wr_s1;
	logic [ADDR_W-1:0]    wr_addr_s1;
	wr_kind_t             wr_kind_s1;

	logic                 accept;
	action_t              act;
	logic [ADDR_W-1:0]    cur_addr;
	logic [COL_W:0]       col_n;
	logic [ROW_W:0]       row_n;
	logic                 put_we;
	logic [ADDR_W-1:0]    put_addr;
	logic [CELL_W-1:0]    put_data;
	logic                 scroll;
	logic                 sweep_last;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [CELL_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [CELL_W-1:0]    ram_rdata;

	assign in_ch.ready = (state_q == ST_IDLE) && !wr_s1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign act         = action_t'(in_ch.action);
	assign sweep_last  = (sweep_q == ADDR_W'(LAST_CELL));
	assign cur_addr    = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

	// Cursor update and cell write for a put beat
	always_comb begin
		col_n    = (COL_W+1)'(col_q);
		row_n    = (ROW_W+1)'(row_q);
		put_we   = 1'b0;
		put_addr = cur_addr;
		put_data = {attr_q, in_ch.char_code};
		case (in_ch.char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_n = (COL_W+1)'(col_q) - (COL_W+1)'(1);
				end else if (row_q != '0) begin
					row_n    = (ROW_W+1)'(row_q) - (ROW_W+1)'(1);
					col_n    = (COL_W+1)'(COLUMNS - 1);
					put_we   = 1'b1;
					put_addr = cur_addr - ADDR_W'(1);
					put_data = '0;
				end
			end
			CH_CR: begin
				col_n = '0;
			end
			CH_LF: begin
				col_n = '0;
				row_n = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
			end
			default: begin
				// printable: 0x20 to 0x7F
				if (in_ch.char_code >= CH_SPACE && !in_ch.char_code[CHAR_W-1]) begin
					put_we = 1'b1;
					col_n  = (COL_W+1)'(col_q) + (COL_W+1)'(1);
				end
			end
		endcase
		// wrap at the row end
		if (col_n >= (COL_W+1)'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + (ROW_W+1)'(1);
		end
		put_we = put_we && accept && (act == ACT_PUT);
	end

	assign scroll = (row_n >= (ROW_W+1)'(ROWS));

	// RAM ports: the sweep stage owns the write port whenever it is busy
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = put_addr;
		ram_wdata = put_data;
		if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			case (wr_kind_s1)
				WK_COPY:  ram_wdata = ram_rdata;
				WK_BLANK: ram_wdata = {attr_q, CH_SPACE};
				default:  ram_wdata = '0;
			endcase
		end else if (put_we) begin
			ram_we = 1'b1;
		end
		ram_raddr = (state_q == ST_SCROLL) ? sweep_q + ADDR_W'(COLUMNS) : in_ch.cell_index;
	end

	tcc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state machine, sweep stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= ATTR_RESET;
			out_valid_q <= 1'b0;
			wr_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			wr_s1      <= 1'b0;
			wr_addr_s1 <= sweep_q;
			wr_kind_s1 <= WK_ZERO;
			unique case (state_q)
				ST_INIT, ST_CLEAR, ST_SCROLL: begin
					wr_s1 <= 1'b1;
					if (state_q == ST_SCROLL) begin
						wr_kind_s1 <= (sweep_q < ADDR_W'(COPY_CELLS)) ? WK_COPY : WK_BLANK;
					end
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_data_q <= '0;
						unique case (act)
							ACT_PUT: begin
								if (scroll) begin
									col_q   <= '0;
									row_q   <= ROW_W'(ROWS - 1);
									state_q <= ST_SCROLL;
								end else begin
									col_q   <= COL_W'(col_n);
									row_q   <= ROW_W'(row_n);
									state_q <= ST_DONE;
								end
							end
							ACT_READ: begin
								state_q <= (in_ch.cell_index < ADDR_W'(CELL_COUNT)) ?
									ST_READ : ST_DONE;
							end
							ACT_CLEAR: begin
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					res_data_q <= ram_rdata;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_col_q   <= col_q;
						out_row_q   <= row_q;
						out_data_q  <= res_data_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.cursor_column = out_col_q;
	assign out_ch.cursor_row    = out_row_q;
	assign out_ch.cell_data     = out_data_q;

	// Cursor never leaves the screen
	`TCC_ASSERT_IMPL(a_col_range, 1'b1, col_q < COL_W'(COLUMNS))
	`TCC_ASSERT_IMPL(a_row_range, 1'b1, row_q < ROW_W'(ROWS))
	// A scroll runs with the cursor parked at the start of the bottom row
	`TCC_ASSERT_IMPL(a_scroll_cursor, state_q == ST_SCROLL,
		col_q == '0 && row_q == ROW_W'(ROWS - 1))
	// A new result only comes out of the done state
	`TCC_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE))
	// An in-range read beat always enters the read state on the following cycle
	`TCC_ASSERT_NEXT(a_read_next, accept && act == ACT_READ &&
		in_ch.cell_index < ADDR_W'(CELL_COUNT), state_q == ST_READ)

endmodule
